// File: rtl/multi_channel_length_prefix_deframer_macros.svh
// Assertion helpers, clocked on clock and disabled during reset.
`ifndef MULTI_CHANNEL_LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define MULTI_CHANNEL_LENGTH_PREFIX_DEFRAMER_MACROS_SVH

// Same-cycle implication
`define MCD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Next-cycle implication
`define MCD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

// File: rtl/mcd_pkg.sv
package mcd_pkg;

   localparam int NUM_CONN  = 16;   // 1 .. 16, conn_index is 4 bits
   localparam int CONN_W    = 4;
   localparam int ADDR_W    = (NUM_CONN > 1) ? $clog2(NUM_CONN) : 1;
   localparam int LEN_W     = 16;
   localparam int BYTE_W    = 8;

   localparam logic [1:0] PH_HIGH    = 2'd0;
   localparam logic [1:0] PH_LOW     = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   typedef struct packed {
      logic [1:0]        header_count;
      logic [BYTE_W-1:0] header_high;
      logic [LEN_W-1:0]  frame_length;
      logic [LEN_W-1:0]  received_count;
   } conn_entry_type;

   localparam int ENTRY_W = $bits(conn_entry_type);

   typedef struct packed {
      logic [CONN_W-1:0] out_conn;
      logic [BYTE_W-1:0] payload_byte;
      logic              byte_valid;
      logic              frame_start;
      logic              frame_end;
   } rsp_item_type;

   typedef struct packed {
      conn_entry_type entry;
      logic           emit;
      rsp_item_type   item;
   } upd_type;

endpackage

// File: rtl/mcd_if.sv
interface mcd_req_if;
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [mcd_pkg::CONN_W-1:0] conn_index;
   logic [mcd_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, kind, conn_index, data_byte, input ready);
   modport sink   (input valid, kind, conn_index, data_byte, output ready);
endinterface

interface mcd_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [mcd_pkg::CONN_W-1:0] out_conn;
   logic [mcd_pkg::BYTE_W-1:0] payload_byte;
   logic                     byte_valid;
   logic                     frame_start;
   logic                     frame_end;

   modport source (output valid, out_conn, payload_byte, byte_valid, frame_start, frame_end,
                   input ready);
   modport sink   (input valid, out_conn, payload_byte, byte_valid, frame_start, frame_end,
                   output ready);
endinterface

// File: rtl/mcd_ram.sv
module mcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mcd_update.sv
module mcd_update (
   input  mcd_pkg::conn_entry_type      entry,
   input  logic                         kind,
   input  logic [mcd_pkg::CONN_W-1:0]   conn,
   input  logic [mcd_pkg::BYTE_W-1:0]   data_byte,
   input  logic                         deliver_en,
   output mcd_pkg::upd_type             upd
);

   logic [mcd_pkg::LEN_W-1:0] len;
   logic [mcd_pkg::LEN_W:0]   got;
   logic                      last;

   assign len  = {entry.header_high, data_byte};
   assign got  = {1'b0, entry.received_count} + {{mcd_pkg::LEN_W{1'b0}}, 1'b1};
   assign last = (got >= {1'b0, entry.frame_length});

   always_comb begin
      upd                   = '0;
      upd.entry             = entry;
      upd.item.out_conn     = conn;
      upd.item.payload_byte = data_byte;
      if (kind == mcd_pkg::KIND_CLOSE) begin
         upd.entry = '0;
      end else begin
         case (entry.header_count)
            mcd_pkg::PH_HIGH: begin
               upd.entry.header_high  = data_byte;
               upd.entry.header_count = mcd_pkg::PH_LOW;
            end
            mcd_pkg::PH_LOW: begin
               if (len == '0) begin
                  // empty frame: marker right away
                  upd.entry             = '0;
                  upd.emit              = deliver_en;
                  upd.item.payload_byte = '0;
                  upd.item.byte_valid   = 1'b0;
                  upd.item.frame_start  = 1'b1;
                  upd.item.frame_end    = 1'b1;
               end else begin
                  upd.entry.frame_length   = len;
                  upd.entry.received_count = '0;
                  upd.entry.header_count   = mcd_pkg::PH_PAYLOAD;
               end
            end
            default: begin
               // payload phase (also the unused phase code)
               upd.emit             = deliver_en;
               upd.item.byte_valid  = 1'b1;
               upd.item.frame_start = (entry.received_count == '0);
               upd.item.frame_end   = last;
               if (last) begin
                  upd.entry = '0;
               end else begin
                  upd.entry.received_count = got[mcd_pkg::LEN_W-1:0];
               end
            end
         endcase
      end
   end

endmodule

// File: rtl/multi_channel_length_prefix_deframer.sv
// An accepted item is registered in stage 1 while its table entry is read; its result then goes
// to the output register. Throughput: one item per cycle unless stage 1 stalls; the connection
// table is read at accept and written back as the item leaves stage 1, with a one-entry forwarding
// register covering back-to-back same-connection items. A full output register that is not taken
// stalls the pipe only when a result is pending. Reset (synchronous, active high): per-entry valid
// bits clear, so every entry reads as zero at once (no clearing pass); deliver_ff returns to 1.
`include "multi_channel_length_prefix_deframer_macros.svh"

module multi_channel_length_prefix_deframer (
   input  logic        clock,
   input  logic        reset,
   mcd_req_if.sink     req_ch,
   mcd_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic deliver_ff, deliver_in;

   // stage 1: item waiting for its table read
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_kind_ff;
   logic [mcd_pkg::CONN_W-1:0]  s1_conn_ff;
   logic [mcd_pkg::BYTE_W-1:0]  s1_byte_ff;

   // last table write, for forwarding
   logic                        fwd_valid_ff, fwd_valid_in;
   logic [mcd_pkg::ADDR_W-1:0]  fwd_addr_ff;
   mcd_pkg::conn_entry_type     fwd_entry_ff;

   logic [mcd_pkg::NUM_CONN-1:0] valid_ff, valid_in;

   logic                        out_valid_ff, out_valid_in;
   mcd_pkg::rsp_item_type       out_item_ff;

   logic                        req_acc;
   logic                        s1_go;
   logic                        s1_in_range;
   logic                        s1_emit;
   logic                        wr_en;
   logic [mcd_pkg::ADDR_W-1:0]  s1_addr;
   logic [mcd_pkg::ENTRY_W-1:0] rd_data;
   mcd_pkg::conn_entry_type     cur_entry;
   mcd_pkg::upd_type            upd;

   assign s1_addr     = s1_conn_ff[mcd_pkg::ADDR_W-1:0];
   assign s1_in_range = ({1'b0, s1_conn_ff} < (mcd_pkg::CONN_W + 1)'(mcd_pkg::NUM_CONN));

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr)) begin
         cur_entry = fwd_entry_ff;
      end else if (valid_ff[s1_addr]) begin
         cur_entry = mcd_pkg::conn_entry_type'(rd_data);
      end else begin
         cur_entry = '0;
      end
   end

   mcd_update u_update (
      .entry      (cur_entry),
      .kind       (s1_kind_ff),
      .conn       (s1_conn_ff),
      .data_byte  (s1_byte_ff),
      .deliver_en (deliver_ff),
      .upd        (upd)
   );

   assign s1_emit      = s1_in_range && upd.emit;
   assign s1_go        = s1_valid_ff && (!s1_emit || !out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign wr_en        = s1_go && s1_in_range;

   mcd_ram #(
      .WIDTH (mcd_pkg::ENTRY_W),
      .DEPTH (mcd_pkg::NUM_CONN)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (upd.entry),
      .rd_en   (req_acc),
      .rd_addr (req_ch.conn_index[mcd_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      deliver_in   = csr_wr_en ? csr_wr_data : deliver_ff;
      s1_valid_in  = req_acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      fwd_valid_in = fwd_valid_ff || wr_en;
      valid_in     = valid_ff;
      if (wr_en) begin
         valid_in[s1_addr] = 1'b1;
      end
      if (s1_go && s1_emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deliver_ff   <= 1'b1;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         deliver_ff   <= deliver_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_kind_ff <= req_ch.kind;
         s1_conn_ff <= req_ch.conn_index;
         s1_byte_ff <= req_ch.data_byte;
      end
      if (wr_en) begin
         fwd_addr_ff  <= s1_addr;
         fwd_entry_ff <= upd.entry;
      end
      if (s1_go && s1_emit) begin
         out_item_ff <= upd.item;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.out_conn     = out_item_ff.out_conn;
   assign rsp_ch.payload_byte = out_item_ff.payload_byte;
   assign rsp_ch.byte_valid   = out_item_ff.byte_valid;
   assign rsp_ch.frame_start  = out_item_ff.frame_start;
   assign rsp_ch.frame_end    = out_item_ff.frame_end;

   `MCD_ASSERT_NEXT(a_stall_holds, s1_valid_ff && !s1_go, s1_valid_ff && $stable(s1_conn_ff))
   `MCD_ASSERT_NEXT(a_accept_loads, req_acc, s1_valid_ff)
   `MCD_ASSERT_IMPL(a_empty_marker, out_valid_ff && !out_item_ff.byte_valid,
                    out_item_ff.frame_start && out_item_ff.frame_end)
   `MCD_ASSERT_IMPL(a_reset_clears, $past(reset), valid_ff == '0 && !s1_valid_ff)

endmodule

// File: test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 300;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   mcd_req_if req_ch ();
   mcd_rsp_if rsp_ch ();

   multi_channel_length_prefix_deframer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state, one entry per connection
   logic [1:0]                 conn_phase    [mcd_pkg::NUM_CONN];
   logic [mcd_pkg::BYTE_W-1:0] conn_len_high [mcd_pkg::NUM_CONN];
   logic [mcd_pkg::LEN_W-1:0]  conn_frame_len[mcd_pkg::NUM_CONN];
   logic [mcd_pkg::LEN_W-1:0]  conn_rx_count [mcd_pkg::NUM_CONN];
   logic                       deliver_on;

   mcd_pkg::rsp_item_type deframed_q[$];

   int  error_count;
   bit  idle_on;
   bit  hold_request;
   int  hold_left;
   int  stall_left;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int exp);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
      error_count++;
   endtask

   task automatic clear_conn(input int c);
      conn_phase[c]     = mcd_pkg::PH_HIGH;
      conn_len_high[c]  = '0;
      conn_frame_len[c] = '0;
      conn_rx_count[c]  = '0;
   endtask

   task automatic deframe_item(input logic kind, input logic [mcd_pkg::CONN_W-1:0] conn,
                               input logic [mcd_pkg::BYTE_W-1:0] data);
      mcd_pkg::rsp_item_type     res;
      logic [mcd_pkg::LEN_W-1:0] len;
      logic [mcd_pkg::LEN_W:0]   got;
      int c;
      c = int'(conn);
      res = '0;
      res.out_conn = conn;
      if (c >= mcd_pkg::NUM_CONN) begin
         return;
      end
      if (kind == mcd_pkg::KIND_CLOSE) begin
         clear_conn(c);
         return;
      end
      if (conn_phase[c] == mcd_pkg::PH_HIGH) begin
         conn_len_high[c] = data;
         conn_phase[c] = mcd_pkg::PH_LOW;
      end else if (conn_phase[c] == mcd_pkg::PH_LOW) begin
         len = {conn_len_high[c], data};
         if (len == '0) begin
            clear_conn(c);
            // empty frame: marker only, no payload byte
            res.frame_start = 1'b1;
            res.frame_end = 1'b1;
            if (deliver_on) deframed_q.push_back(res);
         end else begin
            conn_frame_len[c] = len;
            conn_rx_count[c] = '0;
            conn_phase[c] = mcd_pkg::PH_PAYLOAD;
         end
      end else begin
         // payload phase, the unused phase code lands here too
         res.payload_byte = data;
         res.byte_valid = 1'b1;
         res.frame_start = (conn_rx_count[c] == '0);
         got = {1'b0, conn_rx_count[c]} + {{mcd_pkg::LEN_W{1'b0}}, 1'b1};
         res.frame_end = (got >= {1'b0, conn_frame_len[c]});
         if (res.frame_end) clear_conn(c);
         else conn_rx_count[c] = got[mcd_pkg::LEN_W-1:0];
         if (deliver_on) deframed_q.push_back(res);
      end
   endtask

   task automatic send_item(input logic kind, input logic [mcd_pkg::CONN_W-1:0] conn,
                            input logic [mcd_pkg::BYTE_W-1:0] data);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.conn_index <= conn;
      req_ch.data_byte  <= data;
      do @(posedge clock); while (!req_ch.ready);
      deframe_item(kind, conn, data);
   endtask

   task automatic send_header(input logic [mcd_pkg::CONN_W-1:0] conn,
                              input logic [mcd_pkg::LEN_W-1:0] len);
      send_item(mcd_pkg::KIND_DATA, conn, len[15:8]);
      send_item(mcd_pkg::KIND_DATA, conn, len[7:0]);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (deframed_q.size() != 0) @(posedge clock);
      // a last item may still be in flight without a result
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_deliver(input logic value);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      deliver_on = value;
   endtask

   task automatic test_directed_frames();
      send_header(4'd0, 16'h0000);            // empty frame marker
      send_header(4'd15, 16'h0001);
      send_item(mcd_pkg::KIND_DATA, 4'd15, 8'hFF);
      send_header(4'd3, 16'h0003);
      send_item(mcd_pkg::KIND_DATA, 4'd3, 8'h00);
      send_item(mcd_pkg::KIND_DATA, 4'd3, 8'hA5);
      send_item(mcd_pkg::KIND_DATA, 4'd3, 8'h5A);
      // two connections interleaved item by item
      send_item(mcd_pkg::KIND_DATA, 4'd1, 8'h00);
      send_item(mcd_pkg::KIND_DATA, 4'd2, 8'h00);
      send_item(mcd_pkg::KIND_DATA, 4'd1, 8'h02);
      send_item(mcd_pkg::KIND_DATA, 4'd2, 8'h02);
      send_item(mcd_pkg::KIND_DATA, 4'd1, 8'h11);
      send_item(mcd_pkg::KIND_DATA, 4'd2, 8'h22);
      send_item(mcd_pkg::KIND_DATA, 4'd1, 8'h33);
      send_item(mcd_pkg::KIND_DATA, 4'd2, 8'h44);
      // close in the middle of a payload, then a fresh frame
      send_header(4'd4, 16'h0005);
      send_item(mcd_pkg::KIND_DATA, 4'd4, 8'h77);
      send_item(mcd_pkg::KIND_CLOSE, 4'd4, 8'hFF);
      send_header(4'd4, 16'h0001);
      send_item(mcd_pkg::KIND_DATA, 4'd4, 8'h88);
      // close after the high length byte, and on a connection at rest
      send_item(mcd_pkg::KIND_DATA, 4'd5, 8'hFF);
      send_item(mcd_pkg::KIND_CLOSE, 4'd5, 8'h00);
      send_item(mcd_pkg::KIND_CLOSE, 4'd6, 8'h00);
      send_header(4'd5, 16'h0000);
   endtask

   task automatic test_delivery_disabled();
      set_deliver(1'b0);
      send_header(4'd7, 16'h0000);            // marker dropped
      send_header(4'd7, 16'h0002);
      send_item(mcd_pkg::KIND_DATA, 4'd7, 8'hC3);
      send_item(mcd_pkg::KIND_DATA, 4'd7, 8'h3C);
      send_header(4'd8, 16'h0003);
      send_item(mcd_pkg::KIND_DATA, 4'd8, 8'h01);      // frame continues after re-enable
      set_deliver(1'b1);
      send_item(mcd_pkg::KIND_DATA, 4'd8, 8'h02);
      send_item(mcd_pkg::KIND_DATA, 4'd8, 8'h03);
      send_header(4'd7, 16'h0001);
      send_item(mcd_pkg::KIND_DATA, 4'd7, 8'h99);
   endtask

   task automatic test_random(input int count);
      logic [mcd_pkg::CONN_W-1:0] hot_a;
      logic [mcd_pkg::CONN_W-1:0] hot_b;
      logic [mcd_pkg::CONN_W-1:0] conn;
      logic [mcd_pkg::BYTE_W-1:0] data;
      int r;
      hot_a = 4'($urandom_range(0, mcd_pkg::NUM_CONN - 1));
      hot_b = 4'($urandom_range(0, mcd_pkg::NUM_CONN - 1));
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) conn = 4'($urandom_range(0, mcd_pkg::NUM_CONN - 1));
         else conn = $urandom_range(0, 1) ? hot_a : hot_b;
         r = $urandom_range(0, 99);
         if (r < 4) begin
            send_item(mcd_pkg::KIND_CLOSE, conn, 8'($urandom_range(0, 255)));
         end else begin
            // keep most lengths short so frames complete
            case (conn_phase[conn])
               mcd_pkg::PH_HIGH: data = (r < 9) ? 8'($urandom_range(0, 255)) : 8'h00;
               mcd_pkg::PH_LOW:  data = (r < 9) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 6));
               default: data = 8'($urandom_range(0, 255));
            endcase
            send_item(mcd_pkg::KIND_DATA, conn, data);
         end
      end
   endtask

   task automatic test_backpressure();
      wait_idle();
      idle_on = 1'b0;
      hold_request = 1'b1;
      send_header(4'd9, 16'd30);
      for (int i = 0; i < 30; i++) begin
         send_item(mcd_pkg::KIND_DATA, 4'd9, 8'($urandom_range(0, 255)));
      end
      wait_idle();
      idle_on = 1'b1;
   endtask

   // result side: random stall bursts plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      mcd_pkg::rsp_item_type exp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (deframed_q.size() == 0) begin
            report_mismatch("unexpected item, out_conn", int'(rsp_ch.out_conn), -1);
         end else begin
            exp = deframed_q.pop_front();
            if (rsp_ch.out_conn !== exp.out_conn)
               report_mismatch("out_conn", int'(rsp_ch.out_conn), int'(exp.out_conn));
            if (rsp_ch.payload_byte !== exp.payload_byte)
               report_mismatch("payload_byte", int'(rsp_ch.payload_byte),
                               int'(exp.payload_byte));
            if (rsp_ch.byte_valid !== exp.byte_valid)
               report_mismatch("byte_valid", int'(rsp_ch.byte_valid), int'(exp.byte_valid));
            if (rsp_ch.frame_start !== exp.frame_start)
               report_mismatch("frame_start", int'(rsp_ch.frame_start),
                               int'(exp.frame_start));
            if (rsp_ch.frame_end !== exp.frame_end)
               report_mismatch("frame_end", int'(rsp_ch.frame_end), int'(exp.frame_end));
         end
      end
   end

   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.kind = mcd_pkg::KIND_DATA;
      req_ch.conn_index = '0;
      req_ch.data_byte = '0;
      rsp_ch.ready = 1'b0;
      error_count = 0;
      idle_on = 1'b1;
      hold_request = 1'b0;
      hold_left = 0;
      stall_left = 0;
      for (int c = 0; c < mcd_pkg::NUM_CONN; c++) clear_conn(c);
      deliver_on = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_delivery_disabled();
      test_random(100);
      test_backpressure();
      set_deliver(1'b0);
      test_random(70);
      set_deliver(1'b1);
      test_random(80);
      wait_idle();
      idle_on = 1'b0;
      test_random(80);
      wait_idle();

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
